>>> rtl/core/mse_pkg.sv
`timescale 1ns / 1ps
package mse_pkg;

    // data memory geometry, power of two
    localparam int DMEM_WORDS = 1024;
    localparam int DMEM_AW    = $clog2(DMEM_WORDS);
    // clearing sweep covers the data memory and the register file
    localparam int CLR_CNT    = (DMEM_WORDS > 32) ? DMEM_WORDS : 32;
    localparam int CLR_W      = $clog2(CLR_CNT);

    localparam logic [31:0] START_PC_RST = 32'h0040_0000;
    localparam logic [31:0] V0_HALT      = 32'h0000_000a;
    localparam logic [31:0] JMP_REGION   = 32'hf000_0000;
    localparam logic [4:0]  REG_V0       = 5'd2;
    localparam logic [4:0]  REG_RA       = 5'd31;

    // primary opcodes
    localparam logic [5:0] OP_SPECIAL = 6'h00;
    localparam logic [5:0] OP_REGIMM  = 6'h01;
    localparam logic [5:0] OP_J       = 6'h02;
    localparam logic [5:0] OP_JAL     = 6'h03;
    localparam logic [5:0] OP_BEQ     = 6'h04;
    localparam logic [5:0] OP_BNE     = 6'h05;
    localparam logic [5:0] OP_BLEZ    = 6'h06;
    localparam logic [5:0] OP_BGTZ    = 6'h07;
    localparam logic [5:0] OP_ADDI    = 6'h08;
    localparam logic [5:0] OP_ADDIU   = 6'h09;
    localparam logic [5:0] OP_SLTI    = 6'h0a;
    localparam logic [5:0] OP_SLTIU   = 6'h0b;
    localparam logic [5:0] OP_ANDI    = 6'h0c;
    localparam logic [5:0] OP_ORI     = 6'h0d;
    localparam logic [5:0] OP_XORI    = 6'h0e;
    localparam logic [5:0] OP_LUI     = 6'h0f;
    localparam logic [5:0] OP_LB      = 6'h20;
    localparam logic [5:0] OP_LH      = 6'h21;
    localparam logic [5:0] OP_LW      = 6'h23;
    localparam logic [5:0] OP_LBU     = 6'h24;
    localparam logic [5:0] OP_LHU     = 6'h25;
    localparam logic [5:0] OP_SB      = 6'h28;
    localparam logic [5:0] OP_SH      = 6'h29;
    localparam logic [5:0] OP_SW      = 6'h2b;

    // special function codes
    localparam logic [5:0] FN_SLL     = 6'h00;
    localparam logic [5:0] FN_SRL     = 6'h02;
    localparam logic [5:0] FN_SRA     = 6'h03;
    localparam logic [5:0] FN_SLLV    = 6'h04;
    localparam logic [5:0] FN_SRLV    = 6'h06;
    localparam logic [5:0] FN_SRAV    = 6'h07;
    localparam logic [5:0] FN_JR      = 6'h08;
    localparam logic [5:0] FN_JALR    = 6'h09;
    localparam logic [5:0] FN_SYSCALL = 6'h0c;
    localparam logic [5:0] FN_MFHI    = 6'h10;
    localparam logic [5:0] FN_MTHI    = 6'h11;
    localparam logic [5:0] FN_MFLO    = 6'h12;
    localparam logic [5:0] FN_MTLO    = 6'h13;
    localparam logic [5:0] FN_MULT    = 6'h18;
    localparam logic [5:0] FN_MULTU   = 6'h19;
    localparam logic [5:0] FN_DIV     = 6'h1a;
    localparam logic [5:0] FN_DIVU    = 6'h1b;
    localparam logic [5:0] FN_ADD     = 6'h20;
    localparam logic [5:0] FN_ADDU    = 6'h21;
    localparam logic [5:0] FN_SUB     = 6'h22;
    localparam logic [5:0] FN_SUBU    = 6'h23;
    localparam logic [5:0] FN_AND     = 6'h24;
    localparam logic [5:0] FN_OR      = 6'h25;
    localparam logic [5:0] FN_XOR     = 6'h26;
    localparam logic [5:0] FN_NOR     = 6'h27;
    localparam logic [5:0] FN_SLT     = 6'h2a;
    localparam logic [5:0] FN_SLTU    = 6'h2b;

    // regimm codes
    localparam logic [4:0] RI_BLTZ    = 5'h00;
    localparam logic [4:0] RI_BGEZ    = 5'h01;
    localparam logic [4:0] RI_BLTZAL  = 5'h10;
    localparam logic [4:0] RI_BGEZAL  = 5'h11;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_UNDEF    = 3'd1,
        ST_MISALIGN = 3'd2,
        ST_DIVZERO  = 3'd3,
        ST_HALT     = 3'd4
    } t_status;

    // item class set by the front end
    typedef enum logic [2:0] {
        CLS_PRELOAD,
        CLS_MULT,
        CLS_MULTU,
        CLS_DIV,
        CLS_DIVU,
        CLS_PLAIN
    } t_cls;

    typedef struct packed {
        t_cls        cls;
        logic [31:0] instr;
        logic [9:0]  pidx;
        logic [31:0] pword;
    } t_qent;

    function automatic logic [31:0] sext16(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    function automatic logic [31:0] sext8(input logic [7:0] v);
        return {{24{v[7]}}, v};
    endfunction

endpackage

>>> rtl/core/mse_if.sv
`timescale 1ns / 1ps
interface mse_in_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [31:0] instr_word;
    logic [9:0]  preload_index;
    logic [31:0] preload_word;
    modport source (output valid, req_type, instr_word, preload_index, preload_word,
                    input ready);
    modport sink (input valid, req_type, instr_word, preload_index, preload_word,
                  output ready);
endinterface

interface mse_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] next_pc;
    logic [2:0]  status;
    logic        reg_write_enable;
    logic [4:0]  reg_write_index;
    logic [31:0] reg_write_value;
    logic [31:0] hi_value;
    logic [31:0] lo_value;
    modport source (output valid, next_pc, status, reg_write_enable, reg_write_index,
                    reg_write_value, hi_value, lo_value, input ready);
    modport sink (input valid, next_pc, status, reg_write_enable, reg_write_index,
                  reg_write_value, hi_value, lo_value, output ready);
endinterface

interface mse_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] data;
    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

>>> rtl/core/mips32_subset_execute.sv
`timescale 1ns / 1ps
// channel   dir  carries
// i_in      in   req_type, instr_word, preload_index, preload_word
// o_res     out  next_pc, status, reg write, hi/lo
// i_cfg     in   start_pc write data (also loads the pc)
//
// A word passes through the back end as queue pop, operand read and execute;
// divides by a nonzero divisor also run the one-bit-per-cycle divide loop.
// After reset a clearing pass zeroes data memory and registers;
// no word is accepted during it, config writes are.
// A two-entry queue separates intake from execution; a full result register
// stalls execute only, intake continues until the queue fills.
module mips32_subset_execute (
    input  logic   i_clk,
    input  logic   i_rst_n,
    mse_in_if.sink i_in,
    mse_out_if.source o_res,
    mse_cfg_if.sink i_cfg
);

    logic           push;
    logic           q_full;
    logic           q_valid;
    logic           pop;
    logic           clr_busy;
    mse_pkg::t_qent f_ent;
    mse_pkg::t_qent q_ent;

    mse_front u_front (
        .i_in       (i_in),
        .i_clr_busy (clr_busy),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_ent      (f_ent)
    );

    mse_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_ent   (f_ent),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_ent   (q_ent)
    );

    mse_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (q_valid),
        .i_q_ent    (q_ent),
        .o_pop      (pop),
        .o_clr_busy (clr_busy),
        .i_cfg      (i_cfg),
        .o_res      (o_res)
    );

endmodule

>>> rtl/core/mse_front.sv
`timescale 1ns / 1ps
module mse_front (
    mse_in_if.sink        i_in,
    input  logic          i_clr_busy,
    input  logic          i_q_full,
    output logic          o_push,
    output mse_pkg::t_qent o_ent
);

    logic [5:0] op;
    logic [5:0] fn;

    assign op = i_in.instr_word[31:26];
    assign fn = i_in.instr_word[5:0];

    // hold off while memory is being cleared or the queue is full
    assign i_in.ready = !i_clr_busy && !i_q_full;
    assign o_push     = i_in.valid && i_in.ready;

    // classify the word for the back end
    always_comb begin
        o_ent.instr = i_in.instr_word;
        o_ent.pidx  = i_in.preload_index;
        o_ent.pword = i_in.preload_word;
        o_ent.cls   = mse_pkg::CLS_PLAIN;
        if (i_in.req_type) begin
            o_ent.cls = mse_pkg::CLS_PRELOAD;
        end else if (op == mse_pkg::OP_SPECIAL) begin
            unique case (fn)
                mse_pkg::FN_MULT:  o_ent.cls = mse_pkg::CLS_MULT;
                mse_pkg::FN_MULTU: o_ent.cls = mse_pkg::CLS_MULTU;
                mse_pkg::FN_DIV:   o_ent.cls = mse_pkg::CLS_DIV;
                mse_pkg::FN_DIVU:  o_ent.cls = mse_pkg::CLS_DIVU;
                default:           o_ent.cls = mse_pkg::CLS_PLAIN;
            endcase
        end
    end

endmodule

>>> rtl/core/mse_queue.sv
`timescale 1ns / 1ps
module mse_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  mse_pkg::t_qent i_ent,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output mse_pkg::t_qent o_ent
);

    mse_pkg::t_qent r_mem [2];
    logic           r_wp;
    logic           r_rp;
    logic [1:0]     r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_ent   = r_mem[r_rp];

    // two-entry fifo pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_ent;
        end
    end

endmodule

>>> rtl/core/mse_back.sv
`timescale 1ns / 1ps
module mse_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_valid,
    input  mse_pkg::t_qent i_q_ent,
    output logic           o_pop,
    output logic           o_clr_busy,
    mse_cfg_if.sink        i_cfg,
    mse_out_if.source      o_res
);

    typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_READ, S_DIV, S_EXEC} t_state;

    t_state                      r_state;
    logic [mse_pkg::CLR_W-1:0]   r_clr;
    logic [4:0]                  r_dcnt;
    mse_pkg::t_qent              r_item;
    logic [31:0]                 r_pc;
    logic [31:0]                 r_hi;
    logic [31:0]                 r_lo;
    logic [31:0]                 r_v0;
    logic                        r_halted;
    logic [31:0]                 r_a;
    logic [31:0]                 r_b;
    logic [31:0]                 r_addr;
    logic [31:0]                 r_mword;
    logic [63:0]                 r_prod;
    logic [31:0]                 r_quo;
    logic [31:0]                 r_rem;
    logic [31:0]                 r_dvs;
    logic                        r_qneg;
    logic                        r_rneg;
    logic                        r_out_valid;
    logic [31:0]                 r_out_pc;
    logic [2:0]                  r_out_st;
    logic                        r_out_we;
    logic [4:0]                  r_out_idx;
    logic [31:0]                 r_out_val;
    logic [31:0]                 r_out_hi;
    logic [31:0]                 r_out_lo;

    logic [31:0]                 r_rf [32];
    logic [31:0]                 r_dmem [mse_pkg::DMEM_WORDS];

    // execute results
    logic [31:0]                 n_pc;
    mse_pkg::t_status            n_st;
    logic                        x_wr;
    logic [4:0]                  x_dst;
    logic [31:0]                 x_val;
    logic [31:0]                 n_hi;
    logic [31:0]                 n_lo;
    logic                        x_halt;
    logic                        x_mwe;
    logic [mse_pkg::DMEM_AW-1:0] x_midx;
    logic [31:0]                 x_mdata;
    logic                        x_we;
    logic                        exec_fire;

    // write ports
    logic                        rf_we;
    logic [4:0]                  rf_waddr;
    logic [31:0]                 rf_wdata;
    logic                        dm_we;
    logic [mse_pkg::DMEM_AW-1:0] dm_waddr;
    logic [31:0]                 dm_wdata;

    // instruction fields
    logic [5:0]  op;
    logic [4:0]  rt;
    logic [4:0]  rd;
    logic [4:0]  sh;
    logic [5:0]  fn;
    logic [15:0] imm;
    logic [31:0] simm;
    logic [31:0] pc4;
    logic [31:0] btgt;
    logic [4:0]  lane;
    logic [4:0]  hlane;
    logic [7:0]  ld_byte;
    logic [15:0] ld_half;

    // divide setup and step
    logic                        d_sgn;
    logic                        d_an;
    logic                        d_bn;
    logic [32:0]                 d_trial;
    logic [32:0]                 d_diff;
    logic signed [32:0]          m_a;
    logic signed [32:0]          m_b;
    logic signed [65:0]          m_p;

    assign o_clr_busy  = (r_state == S_CLEAR);
    assign o_pop       = (r_state == S_IDLE) && i_q_valid;
    assign i_cfg.ready = 1'b1;
    assign exec_fire   = (r_state == S_EXEC) && (!r_out_valid || o_res.ready);

    assign op    = r_item.instr[31:26];
    assign rt    = r_item.instr[20:16];
    assign rd    = r_item.instr[15:11];
    assign sh    = r_item.instr[10:6];
    assign fn    = r_item.instr[5:0];
    assign imm   = r_item.instr[15:0];
    assign simm  = mse_pkg::sext16(imm);
    assign pc4   = r_pc + 32'd4;
    assign btgt  = pc4 + {simm[29:0], 2'b00};
    assign lane  = {r_addr[1:0], 3'b000};
    assign hlane = {r_addr[1], 4'b0000};
    assign ld_byte = 8'(r_mword >> lane);
    assign ld_half = 16'(r_mword >> hlane);

    // multiplier operands, sign extended for mult
    assign d_sgn = (r_item.cls == mse_pkg::CLS_MULT) || (r_item.cls == mse_pkg::CLS_DIV);
    assign m_a   = {d_sgn & r_a[31], r_a};
    assign m_b   = {d_sgn & r_b[31], r_b};
    assign m_p   = m_a * m_b;
    assign d_an  = d_sgn & r_a[31];
    assign d_bn  = d_sgn & r_b[31];

    // restoring divide step
    assign d_trial = {r_rem, r_quo[31]};
    assign d_diff  = d_trial - {1'b0, r_dvs};

    // execute decode
    always_comb begin
        n_pc    = pc4;
        n_st    = mse_pkg::ST_OK;
        x_wr    = 1'b0;
        x_dst   = rd;
        x_val   = 32'd0;
        n_hi    = r_hi;
        n_lo    = r_lo;
        x_halt  = 1'b0;
        x_mwe   = 1'b0;
        x_midx  = r_addr[mse_pkg::DMEM_AW+1:2];
        x_mdata = r_b;
        if (r_item.cls == mse_pkg::CLS_PRELOAD) begin
            n_pc    = r_pc;
            n_st    = r_halted ? mse_pkg::ST_HALT : mse_pkg::ST_OK;
            x_mwe   = 1'b1;
            x_midx  = mse_pkg::DMEM_AW'(r_item.pidx);
            x_mdata = r_item.pword;
        end else if (r_halted) begin
            n_pc = r_pc;
            n_st = mse_pkg::ST_HALT;
        end else if (op == mse_pkg::OP_SPECIAL) begin
            x_wr = 1'b1;
            unique case (fn)
                mse_pkg::FN_SLL:  x_val = r_b << sh;
                mse_pkg::FN_SRL:  x_val = r_b >> sh;
                mse_pkg::FN_SRA:  x_val = 32'($signed(r_b) >>> sh);
                mse_pkg::FN_SLLV: x_val = r_b << r_a[4:0];
                mse_pkg::FN_SRLV: x_val = r_b >> r_a[4:0];
                mse_pkg::FN_SRAV: x_val = 32'($signed(r_b) >>> r_a[4:0]);
                mse_pkg::FN_JR: begin
                    x_wr = 1'b0;
                    n_pc = r_a;
                end
                mse_pkg::FN_JALR: begin
                    x_val = pc4;
                    n_pc  = r_a;
                end
                mse_pkg::FN_SYSCALL: begin
                    x_wr = 1'b0;
                    if (r_v0 == mse_pkg::V0_HALT) begin
                        x_halt = 1'b1;
                        n_st   = mse_pkg::ST_HALT;
                    end
                end
                mse_pkg::FN_MFHI: x_val = r_hi;
                mse_pkg::FN_MTHI: begin
                    x_wr = 1'b0;
                    n_hi = r_a;
                end
                mse_pkg::FN_MFLO: x_val = r_lo;
                mse_pkg::FN_MTLO: begin
                    x_wr = 1'b0;
                    n_lo = r_a;
                end
                mse_pkg::FN_MULT, mse_pkg::FN_MULTU: begin
                    x_wr = 1'b0;
                    n_hi = r_prod[63:32];
                    n_lo = r_prod[31:0];
                end
                mse_pkg::FN_DIV, mse_pkg::FN_DIVU: begin
                    x_wr = 1'b0;
                    if (r_b == 32'd0) begin
                        n_st = mse_pkg::ST_DIVZERO;
                    end else begin
                        n_lo = r_qneg ? (32'd0 - r_quo) : r_quo;
                        n_hi = r_rneg ? (32'd0 - r_rem) : r_rem;
                    end
                end
                mse_pkg::FN_ADD, mse_pkg::FN_ADDU: x_val = r_a + r_b;
                mse_pkg::FN_SUB, mse_pkg::FN_SUBU: x_val = r_a - r_b;
                mse_pkg::FN_AND:  x_val = r_a & r_b;
                mse_pkg::FN_OR:   x_val = r_a | r_b;
                mse_pkg::FN_XOR:  x_val = r_a ^ r_b;
                mse_pkg::FN_NOR:  x_val = ~(r_a | r_b);
                mse_pkg::FN_SLT:  x_val = {31'd0, $signed(r_a) < $signed(r_b)};
                mse_pkg::FN_SLTU: x_val = {31'd0, r_a < r_b};
                default: begin
                    x_wr = 1'b0;
                    n_st = mse_pkg::ST_UNDEF;
                end
            endcase
        end else if (op == mse_pkg::OP_REGIMM) begin
            x_dst = mse_pkg::REG_RA;
            x_val = pc4;
            unique case (rt)
                mse_pkg::RI_BLTZ: begin
                    if (r_a[31]) n_pc = btgt;
                end
                mse_pkg::RI_BGEZ: begin
                    if (!r_a[31]) n_pc = btgt;
                end
                mse_pkg::RI_BLTZAL: begin
                    x_wr = 1'b1;
                    if (r_a[31]) n_pc = btgt;
                end
                mse_pkg::RI_BGEZAL: begin
                    x_wr = 1'b1;
                    if (!r_a[31]) n_pc = btgt;
                end
                default: n_st = mse_pkg::ST_UNDEF;
            endcase
        end else if ((op == mse_pkg::OP_J) || (op == mse_pkg::OP_JAL)) begin
            n_pc  = (pc4 & mse_pkg::JMP_REGION) | {4'd0, r_item.instr[25:0], 2'b00};
            x_wr  = (op == mse_pkg::OP_JAL);
            x_dst = mse_pkg::REG_RA;
            x_val = pc4;
        end else begin
            x_dst = rt;
            unique case (op)
                mse_pkg::OP_BEQ: begin
                    if (r_a == r_b) n_pc = btgt;
                end
                mse_pkg::OP_BNE: begin
                    if (r_a != r_b) n_pc = btgt;
                end
                mse_pkg::OP_BLEZ: begin
                    if ((r_a == 32'd0) || r_a[31]) n_pc = btgt;
                end
                mse_pkg::OP_BGTZ: begin
                    if ((r_a != 32'd0) && !r_a[31]) n_pc = btgt;
                end
                mse_pkg::OP_ADDI, mse_pkg::OP_ADDIU: begin
                    x_wr  = 1'b1;
                    x_val = r_addr;
                end
                mse_pkg::OP_SLTI: begin
                    x_wr  = 1'b1;
                    x_val = {31'd0, $signed(r_a) < $signed(simm)};
                end
                mse_pkg::OP_SLTIU: begin
                    x_wr  = 1'b1;
                    x_val = {31'd0, r_a < simm};
                end
                mse_pkg::OP_ANDI: begin
                    x_wr  = 1'b1;
                    x_val = r_a & {16'd0, imm};
                end
                mse_pkg::OP_ORI: begin
                    x_wr  = 1'b1;
                    x_val = r_a | {16'd0, imm};
                end
                mse_pkg::OP_XORI: begin
                    x_wr  = 1'b1;
                    x_val = r_a ^ {16'd0, imm};
                end
                mse_pkg::OP_LUI: begin
                    x_wr  = 1'b1;
                    x_val = {imm, 16'd0};
                end
                mse_pkg::OP_LB: begin
                    x_wr  = 1'b1;
                    x_val = mse_pkg::sext8(ld_byte);
                end
                mse_pkg::OP_LBU: begin
                    x_wr  = 1'b1;
                    x_val = {24'd0, ld_byte};
                end
                mse_pkg::OP_LH, mse_pkg::OP_LHU: begin
                    if (r_addr[0]) begin
                        n_st = mse_pkg::ST_MISALIGN;
                    end else begin
                        x_wr  = 1'b1;
                        x_val = (op == mse_pkg::OP_LH) ? mse_pkg::sext16(ld_half)
                                                       : {16'd0, ld_half};
                    end
                end
                mse_pkg::OP_LW: begin
                    if (r_addr[1:0] != 2'b00) begin
                        n_st = mse_pkg::ST_MISALIGN;
                    end else begin
                        x_wr  = 1'b1;
                        x_val = r_mword;
                    end
                end
                mse_pkg::OP_SB: begin
                    x_mwe   = 1'b1;
                    x_mdata = (r_mword & ~(32'h0000_00ff << lane))
                            | ({24'd0, r_b[7:0]} << lane);
                end
                mse_pkg::OP_SH: begin
                    if (r_addr[0]) begin
                        n_st = mse_pkg::ST_MISALIGN;
                    end else begin
                        x_mwe   = 1'b1;
                        x_mdata = (r_mword & ~(32'h0000_ffff << hlane))
                                | ({16'd0, r_b[15:0]} << hlane);
                    end
                end
                mse_pkg::OP_SW: begin
                    if (r_addr[1:0] != 2'b00) begin
                        n_st = mse_pkg::ST_MISALIGN;
                    end else begin
                        x_mwe = 1'b1;
                    end
                end
                default: n_st = mse_pkg::ST_UNDEF;
            endcase
        end
    end

    assign x_we = x_wr && (x_dst != 5'd0);

    // write port selection, clearing sweep or commit
    always_comb begin
        rf_we    = 1'b0;
        rf_waddr = x_dst;
        rf_wdata = x_val;
        dm_we    = 1'b0;
        dm_waddr = x_midx;
        dm_wdata = x_mdata;
        if (r_state == S_CLEAR) begin
            rf_we    = 1'b1;
            rf_waddr = r_clr[4:0];
            rf_wdata = 32'd0;
            dm_we    = 1'b1;
            dm_waddr = r_clr[mse_pkg::DMEM_AW-1:0];
            dm_wdata = 32'd0;
        end else if (exec_fire) begin
            rf_we = x_we;
            dm_we = x_mwe;
        end
    end

    // register file, two registered read ports
    always_ff @(posedge i_clk) begin
        if (rf_we) begin
            r_rf[rf_waddr] <= rf_wdata;
        end
        if (o_pop) begin
            r_a <= r_rf[i_q_ent.instr[25:21]];
            r_b <= r_rf[i_q_ent.instr[20:16]];
        end
    end

    // data memory, registered read
    always_ff @(posedge i_clk) begin
        if (dm_we) begin
            r_dmem[dm_waddr] <= dm_wdata;
        end
        if (r_state == S_READ) begin
            r_mword <= r_dmem[r_a[mse_pkg::DMEM_AW+1:2] + simm[mse_pkg::DMEM_AW+1:2]
                              + mse_pkg::DMEM_AW'(r_a[1:0] + simm[1:0] > 3'd3)];
        end
    end

    // sequencer, architectural state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_pc        <= mse_pkg::START_PC_RST;
            r_hi        <= 32'd0;
            r_lo        <= 32'd0;
            r_v0        <= 32'd0;
            r_halted    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg.valid) begin
                r_pc <= i_cfg.data;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == mse_pkg::CLR_W'(mse_pkg::CLR_CNT - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_item  <= i_q_ent;
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    r_addr <= r_a + simm;
                    r_prod <= 64'(m_p);
                    r_quo  <= d_an ? (32'd0 - r_a) : r_a;
                    r_dvs  <= d_bn ? (32'd0 - r_b) : r_b;
                    r_rem  <= 32'd0;
                    r_qneg <= d_an ^ d_bn;
                    r_rneg <= d_an;
                    r_dcnt <= 5'd0;
                    if (((r_item.cls == mse_pkg::CLS_DIV) || (r_item.cls == mse_pkg::CLS_DIVU))
                        && (r_b != 32'd0) && !r_halted) begin
                        r_state <= S_DIV;
                    end else begin
                        r_state <= S_EXEC;
                    end
                end
                S_DIV: begin
                    r_dcnt <= r_dcnt + 5'd1;
                    if (!d_diff[32]) begin
                        r_rem <= d_diff[31:0];
                    end else begin
                        r_rem <= d_trial[31:0];
                    end
                    r_quo <= {r_quo[30:0], !d_diff[32]};
                    if (r_dcnt == 5'd31) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (exec_fire) begin
                        r_pc        <= n_pc;
                        r_hi        <= n_hi;
                        r_lo        <= n_lo;
                        r_halted    <= r_halted | x_halt;
                        if (x_we && (x_dst == mse_pkg::REG_V0)) begin
                            r_v0 <= x_val;
                        end
                        r_out_valid <= 1'b1;
                        r_out_pc    <= n_pc;
                        r_out_st    <= n_st;
                        r_out_we    <= x_we;
                        r_out_idx   <= x_we ? x_dst : 5'd0;
                        r_out_val   <= x_we ? x_val : 32'd0;
                        r_out_hi    <= n_hi;
                        r_out_lo    <= n_lo;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_res.valid            = r_out_valid;
    assign o_res.next_pc          = r_out_pc;
    assign o_res.status           = r_out_st;
    assign o_res.reg_write_enable = r_out_we;
    assign o_res.reg_write_index  = r_out_idx;
    assign o_res.reg_write_value  = r_out_val;
    assign o_res.hi_value         = r_out_hi;
    assign o_res.lo_value         = r_out_lo;

    // no item leaves the queue during the clearing sweep
    a_no_pop_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !o_pop)
        else $error("queue popped during clearing");

    // register zero only ever receives zero
    a_r0_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (rf_we && (rf_waddr == 5'd0)) |-> (rf_wdata == 32'd0))
        else $error("nonzero write to register zero");

    // divide iterations end in execute
    a_div_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |=> ((r_state == S_DIV) || (r_state == S_EXEC)))
        else $error("divide left to wrong state");

    // a result word is loaded only from execute
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_out_valid && (r_state != S_EXEC)) |=> !r_out_valid)
        else $error("result loaded outside execute");

endmodule

>>> bench/mse_checker.sv
`timescale 1ns / 1ps
module mse_checker (
    input  logic  i_clk,
    input  logic  i_rst_n,
    mse_in_if     i_in,
    mse_out_if    i_res,
    mse_cfg_if    i_cfg,
    output int    o_fail_cnt,
    output int    o_pending
);

    typedef struct packed {
        logic [31:0] next_pc;
        logic [2:0]  status;
        logic        we;
        logic [4:0]  widx;
        logic [31:0] wval;
        logic [31:0] hi;
        logic [31:0] lo;
    } t_res;

    // shadow core state
    logic [31:0] gpr [32];
    logic [31:0] dmem [mse_pkg::DMEM_WORDS];
    logic [31:0] pc_q, hi_q, lo_q;
    logic        halted_q;

    t_res exp_results[$];

    assign o_pending = exp_results.size();

    function automatic logic [31:0] sext_byte(input logic [31:0] v);
        return {{24{v[7]}}, v[7:0]};
    endfunction

    function automatic logic [31:0] sext_half(input logic [31:0] v);
        return {{16{v[15]}}, v[15:0]};
    endfunction

    // execute one word against the shadow state
    task automatic run_word(input logic ptype, input logic [31:0] ins,
                            input logic [9:0] pidx, input logic [31:0] pword,
                            output t_res r);
        logic [5:0]  op, fn;
        logic [4:0]  rs, rt, rd, sh, dst;
        logic [15:0] imm;
        logic [31:0] simm, a, b, pc4, boff, addr, mword, val, ma, mb, q, rm;
        logic [63:0] prod;
        logic [mse_pkg::DMEM_AW-1:0] wi;
        int          lane, hlane;
        logic        wr, neg, an, bn;
        r = '0;
        r.next_pc = pc_q;
        if (ptype) begin
            dmem[pidx] = pword;
            r.status = halted_q ? mse_pkg::ST_HALT : mse_pkg::ST_OK;
        end else if (halted_q) begin
            r.status = mse_pkg::ST_HALT;
        end else begin
            op = ins[31:26]; rs = ins[25:21]; rt = ins[20:16]; rd = ins[15:11];
            sh = ins[10:6]; fn = ins[5:0]; imm = ins[15:0];
            simm = {{16{imm[15]}}, imm};
            a = gpr[rs]; b = gpr[rt];
            pc4 = pc_q + 32'd4;
            boff = simm << 2;
            addr = a + simm;
            wi = addr[mse_pkg::DMEM_AW+1:2];
            mword = dmem[wi];
            lane = addr[1:0] * 8;
            hlane = addr[1] * 16;
            wr = 1'b0; dst = '0; val = '0;
            r.next_pc = pc4;
            if (op == mse_pkg::OP_SPECIAL) begin
                dst = rd;
                wr = 1'b1;
                case (fn)
                    mse_pkg::FN_SLL:  val = b << sh;
                    mse_pkg::FN_SRL:  val = b >> sh;
                    mse_pkg::FN_SRA:  val = $signed(b) >>> sh;
                    mse_pkg::FN_SLLV: val = b << a[4:0];
                    mse_pkg::FN_SRLV: val = b >> a[4:0];
                    mse_pkg::FN_SRAV: val = $signed(b) >>> a[4:0];
                    mse_pkg::FN_JR: begin wr = 1'b0; r.next_pc = a; end
                    mse_pkg::FN_JALR: begin val = pc4; r.next_pc = a; end
                    mse_pkg::FN_SYSCALL: begin
                        wr = 1'b0;
                        if (gpr[mse_pkg::REG_V0] == mse_pkg::V0_HALT) begin
                            halted_q = 1'b1;
                            r.status = mse_pkg::ST_HALT;
                        end
                    end
                    mse_pkg::FN_MFHI: val = hi_q;
                    mse_pkg::FN_MTHI: begin wr = 1'b0; hi_q = a; end
                    mse_pkg::FN_MFLO: val = lo_q;
                    mse_pkg::FN_MTLO: begin wr = 1'b0; lo_q = a; end
                    mse_pkg::FN_MULT: begin
                        prod = {{32{a[31]}}, a} * {{32{b[31]}}, b};
                        hi_q = prod[63:32]; lo_q = prod[31:0]; wr = 1'b0;
                    end
                    mse_pkg::FN_MULTU: begin
                        prod = {32'd0, a} * {32'd0, b};
                        hi_q = prod[63:32]; lo_q = prod[31:0]; wr = 1'b0;
                    end
                    mse_pkg::FN_DIV: begin
                        wr = 1'b0;
                        if (b == 0) r.status = mse_pkg::ST_DIVZERO;
                        else begin
                            an = a[31]; bn = b[31];
                            ma = an ? -a : a; mb = bn ? -b : b;
                            q = ma / mb; rm = ma % mb;
                            lo_q = (an != bn) ? -q : q;
                            hi_q = an ? -rm : rm;
                        end
                    end
                    mse_pkg::FN_DIVU: begin
                        wr = 1'b0;
                        if (b == 0) r.status = mse_pkg::ST_DIVZERO;
                        else begin lo_q = a / b; hi_q = a % b; end
                    end
                    mse_pkg::FN_ADD, mse_pkg::FN_ADDU: val = a + b;
                    mse_pkg::FN_SUB, mse_pkg::FN_SUBU: val = a - b;
                    mse_pkg::FN_AND:  val = a & b;
                    mse_pkg::FN_OR:   val = a | b;
                    mse_pkg::FN_XOR:  val = a ^ b;
                    mse_pkg::FN_NOR:  val = ~(a | b);
                    mse_pkg::FN_SLT:  val = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
                    mse_pkg::FN_SLTU: val = (a < b) ? 32'd1 : 32'd0;
                    default: begin wr = 1'b0; r.status = mse_pkg::ST_UNDEF; end
                endcase
            end else if (op == mse_pkg::OP_REGIMM) begin
                neg = a[31];
                case (rt)
                    mse_pkg::RI_BLTZ: if (neg) r.next_pc = pc4 + boff;
                    mse_pkg::RI_BGEZ: if (!neg) r.next_pc = pc4 + boff;
                    mse_pkg::RI_BLTZAL: begin
                        wr = 1'b1; dst = mse_pkg::REG_RA; val = pc4;
                        if (neg) r.next_pc = pc4 + boff;
                    end
                    mse_pkg::RI_BGEZAL: begin
                        wr = 1'b1; dst = mse_pkg::REG_RA; val = pc4;
                        if (!neg) r.next_pc = pc4 + boff;
                    end
                    default: r.status = mse_pkg::ST_UNDEF;
                endcase
            end else if (op == mse_pkg::OP_J || op == mse_pkg::OP_JAL) begin
                r.next_pc = (pc4 & mse_pkg::JMP_REGION) | {4'd0, ins[25:0], 2'b00};
                if (op == mse_pkg::OP_JAL) begin
                    wr = 1'b1; dst = mse_pkg::REG_RA; val = pc4;
                end
            end else begin
                dst = rt;
                case (op)
                    mse_pkg::OP_BEQ:  if (a == b) r.next_pc = pc4 + boff;
                    mse_pkg::OP_BNE:  if (a != b) r.next_pc = pc4 + boff;
                    mse_pkg::OP_BLEZ: if (a == 0 || a[31]) r.next_pc = pc4 + boff;
                    mse_pkg::OP_BGTZ: if (a != 0 && !a[31]) r.next_pc = pc4 + boff;
                    mse_pkg::OP_ADDI, mse_pkg::OP_ADDIU: begin
                        wr = 1'b1; val = a + simm;
                    end
                    mse_pkg::OP_SLTI: begin
                        wr = 1'b1; val = ($signed(a) < $signed(simm)) ? 32'd1 : 32'd0;
                    end
                    mse_pkg::OP_SLTIU: begin
                        wr = 1'b1; val = (a < simm) ? 32'd1 : 32'd0;
                    end
                    mse_pkg::OP_ANDI: begin wr = 1'b1; val = a & {16'd0, imm}; end
                    mse_pkg::OP_ORI:  begin wr = 1'b1; val = a | {16'd0, imm}; end
                    mse_pkg::OP_XORI: begin wr = 1'b1; val = a ^ {16'd0, imm}; end
                    mse_pkg::OP_LUI:  begin wr = 1'b1; val = {imm, 16'd0}; end
                    mse_pkg::OP_LB: begin
                        wr = 1'b1; val = sext_byte(mword >> lane);
                    end
                    mse_pkg::OP_LBU: begin
                        wr = 1'b1; val = (mword >> lane) & 32'hff;
                    end
                    mse_pkg::OP_LH: begin
                        if (addr[0]) r.status = mse_pkg::ST_MISALIGN;
                        else begin wr = 1'b1; val = sext_half(mword >> hlane); end
                    end
                    mse_pkg::OP_LHU: begin
                        if (addr[0]) r.status = mse_pkg::ST_MISALIGN;
                        else begin wr = 1'b1; val = (mword >> hlane) & 32'hffff; end
                    end
                    mse_pkg::OP_LW: begin
                        if (addr[1:0] != 0) r.status = mse_pkg::ST_MISALIGN;
                        else begin wr = 1'b1; val = mword; end
                    end
                    mse_pkg::OP_SB: begin
                        dmem[wi] = (mword & ~(32'hff << lane)) | ((b & 32'hff) << lane);
                    end
                    mse_pkg::OP_SH: begin
                        if (addr[0]) r.status = mse_pkg::ST_MISALIGN;
                        else dmem[wi] = (mword & ~(32'hffff << hlane))
                                        | ((b & 32'hffff) << hlane);
                    end
                    mse_pkg::OP_SW: begin
                        if (addr[1:0] != 0) r.status = mse_pkg::ST_MISALIGN;
                        else dmem[wi] = b;
                    end
                    default: r.status = mse_pkg::ST_UNDEF;
                endcase
            end
            // register zero never takes a write
            if (wr && dst != 0) begin
                gpr[dst] = val;
                r.we = 1'b1; r.widx = dst; r.wval = val;
            end
            pc_q = r.next_pc;
        end
        r.hi = hi_q;
        r.lo = lo_q;
    endtask

    // watch the channels at each rising edge
    always @(posedge i_clk) begin
        t_res got, want;
        if (!i_rst_n) begin
            for (int i = 0; i < 32; i++) gpr[i] = '0;
            for (int i = 0; i < mse_pkg::DMEM_WORDS; i++) dmem[i] = '0;
            pc_q = mse_pkg::START_PC_RST;
            hi_q = '0; lo_q = '0; halted_q = 1'b0;
            o_fail_cnt = 0;
            exp_results.delete();
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                pc_q = i_cfg.data;
            end
            // compare a returned word first, then predict a new one
            if (i_res.valid && i_res.ready) begin
                got = '{i_res.next_pc, i_res.status, i_res.reg_write_enable,
                        i_res.reg_write_index, i_res.reg_write_value,
                        i_res.hi_value, i_res.lo_value};
                if (exp_results.size() == 0) begin
                    o_fail_cnt++;
                    if (o_fail_cnt <= 10)
                        $display("%0t: unexpected result word %h", $realtime, got);
                end else begin
                    want = exp_results.pop_front();
                    if (got !== want) begin
                        o_fail_cnt++;
                        if (o_fail_cnt <= 10)
                            $display({"%0t: mismatch pc %h/%h st %0d/%0d we %b/%b ",
                                      "idx %0d/%0d val %h/%h hi %h/%h lo %h/%h"},
                                     $realtime, want.next_pc, got.next_pc,
                                     want.status, got.status, want.we, got.we,
                                     want.widx, got.widx, want.wval, got.wval,
                                     want.hi, got.hi, want.lo, got.lo);
                    end
                end
            end
            if (i_in.valid && i_in.ready) begin
                run_word(i_in.req_type, i_in.instr_word, i_in.preload_index,
                         i_in.preload_word, want);
                exp_results.push_back(want);
            end
        end
    end

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps
module tb;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   fail_cnt, pending;
    int   words_sent = 0;
    logic calm = 1'b0;
    logic sending = 1'b1;

    mse_in_if  in_ch ();
    mse_out_if res_ch ();
    mse_cfg_if cfg_ch ();

    mips32_subset_execute dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_res   (res_ch),
        .i_cfg   (cfg_ch)
    );

    mse_checker chk (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .i_res      (res_ch),
        .i_cfg      (cfg_ch),
        .o_fail_cnt (fail_cnt),
        .o_pending  (pending)
    );

    always #4 i_clk = ~i_clk;

    // run limit
    initial begin
        #5ms;
        $display("FAIL");
        $finish;
    end

    function automatic logic [31:0] enc_r(input logic [4:0] rs, rt, rd, sh,
                                          input logic [5:0] fn);
        return {mse_pkg::OP_SPECIAL, rs, rt, rd, sh, fn};
    endfunction

    function automatic logic [31:0] enc_i(input logic [5:0] op, input logic [4:0] rs, rt,
                                          input logic [15:0] imm);
        return {op, rs, rt, imm};
    endfunction

    // one word on the input channel, with an optional gap afterwards
    task automatic send_word(input logic ptype, input logic [31:0] ins,
                             input logic [9:0] pidx, input logic [31:0] pword);
        int gap;
        in_ch.valid = 1'b1;
        in_ch.req_type = ptype;
        in_ch.instr_word = ins;
        in_ch.preload_index = pidx;
        in_ch.preload_word = pword;
        do @(posedge i_clk); while (!in_ch.ready);
        words_sent++;
        @(negedge i_clk);
        if (!calm && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 14);
            in_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    task automatic exec(input logic [31:0] ins);
        send_word(1'b0, ins, 10'($urandom), $urandom);
    endtask

    // wait for the block to go idle, then load a new start pc
    task automatic write_start_pc(input logic [31:0] v);
        in_ch.valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (45) @(negedge i_clk);
        cfg_ch.valid = 1'b1;
        cfg_ch.data = v;
        do @(posedge i_clk); while (!cfg_ch.ready);
        @(negedge i_clk);
        cfg_ch.valid = 1'b0;
    endtask

    function automatic logic [4:0] pick_reg();
        return $urandom_range(0, 3) == 0 ? 5'($urandom) : 5'($urandom_range(8, 15));
    endfunction

    // random instruction, mostly legal, never a halting call
    function automatic logic [31:0] rand_instr();
        logic [5:0] fns [27] = '{mse_pkg::FN_SLL, mse_pkg::FN_SRL, mse_pkg::FN_SRA,
            mse_pkg::FN_SLLV, mse_pkg::FN_SRLV, mse_pkg::FN_SRAV, mse_pkg::FN_JR,
            mse_pkg::FN_JALR, mse_pkg::FN_MFHI, mse_pkg::FN_MTHI, mse_pkg::FN_MFLO,
            mse_pkg::FN_MTLO, mse_pkg::FN_MULT, mse_pkg::FN_MULTU, mse_pkg::FN_DIV,
            mse_pkg::FN_DIVU, mse_pkg::FN_ADD, mse_pkg::FN_ADDU, mse_pkg::FN_SUB,
            mse_pkg::FN_SUBU, mse_pkg::FN_AND, mse_pkg::FN_OR, mse_pkg::FN_XOR,
            mse_pkg::FN_NOR, mse_pkg::FN_SLT, mse_pkg::FN_SLTU, mse_pkg::FN_ADDU};
        logic [5:0] ops [20] = '{mse_pkg::OP_BEQ, mse_pkg::OP_BNE, mse_pkg::OP_BLEZ,
            mse_pkg::OP_BGTZ, mse_pkg::OP_ADDI, mse_pkg::OP_ADDIU, mse_pkg::OP_SLTI,
            mse_pkg::OP_SLTIU, mse_pkg::OP_ANDI, mse_pkg::OP_ORI, mse_pkg::OP_XORI,
            mse_pkg::OP_LUI, mse_pkg::OP_LB, mse_pkg::OP_LH, mse_pkg::OP_LW,
            mse_pkg::OP_LBU, mse_pkg::OP_LHU, mse_pkg::OP_SB, mse_pkg::OP_SH,
            mse_pkg::OP_SW};
        logic [4:0] ris [4] = '{mse_pkg::RI_BLTZ, mse_pkg::RI_BGEZ, mse_pkg::RI_BLTZAL,
            mse_pkg::RI_BGEZAL};
        logic [31:0] w;
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 40)
            w = enc_r(pick_reg(), pick_reg(), pick_reg(), 5'($urandom),
                      fns[$urandom_range(0, 26)]);
        else if (sel < 85)
            w = enc_i(ops[$urandom_range(0, 19)], pick_reg(), pick_reg(), 16'($urandom));
        else if (sel < 90)
            w = enc_i(mse_pkg::OP_REGIMM, pick_reg(), ris[$urandom_range(0, 3)],
                      16'($urandom));
        else if (sel < 94)
            w = {($urandom_range(0, 1) ? mse_pkg::OP_JAL : mse_pkg::OP_J), 26'($urandom)};
        else
            w = $urandom;
        if (w[31:26] == mse_pkg::OP_SPECIAL && w[5:0] == mse_pkg::FN_SYSCALL)
            w[5:0] = mse_pkg::FN_ADDU;
        return w;
    endfunction

    // result side: random stalls, one long hold-off, none at the end
    initial begin
        int n;
        logic held;
        held = 1'b0;
        res_ch.ready = 1'b0;
        @(negedge i_clk);
        while (sending || pending != 0) begin
            if (!held && words_sent >= 300) begin
                res_ch.ready = 1'b0;
                repeat (300) @(negedge i_clk);
                held = 1'b1;
            end else if (calm) begin
                res_ch.ready = 1'b1;
                @(negedge i_clk);
            end else begin
                n = $urandom_range(1, 14);
                res_ch.ready = $urandom_range(0, 2) != 0;
                repeat (n) @(negedge i_clk);
            end
        end
        res_ch.ready = 1'b1;
    end

    // stimulus and verdict
    initial begin
        logic [31:0] pcs [3];
        in_ch.valid = 1'b0;
        in_ch.req_type = 1'b0;
        in_ch.instr_word = '0;
        in_ch.preload_index = '0;
        in_ch.preload_word = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;
        write_start_pc(32'h0000_1000);

        // directed: extremes, many kinds of word, special cases
        exec(enc_i(mse_pkg::OP_LUI, 5'd0, 5'd8, 16'h8000));
        exec(enc_i(mse_pkg::OP_ADDIU, 5'd0, 5'd10, 16'hffff));
        exec(enc_i(mse_pkg::OP_ORI, 5'd0, 5'd9, 16'hffff));
        exec(enc_r(5'd8, 5'd10, 5'd11, 5'd0, mse_pkg::FN_DIV));
        exec(enc_r(5'd8, 5'd0, 5'd0, 5'd0, mse_pkg::FN_DIV));
        exec(enc_r(5'd10, 5'd9, 5'd0, 5'd0, mse_pkg::FN_DIVU));
        exec(enc_r(5'd8, 5'd10, 5'd0, 5'd0, mse_pkg::FN_MULT));
        exec(enc_r(5'd10, 5'd10, 5'd0, 5'd0, mse_pkg::FN_MULTU));
        exec(enc_r(5'd0, 5'd0, 5'd12, 5'd0, mse_pkg::FN_MFHI));
        exec(enc_r(5'd0, 5'd0, 5'd13, 5'd0, mse_pkg::FN_MFLO));
        exec(enc_r(5'd9, 5'd0, 5'd0, 5'd0, mse_pkg::FN_MTHI));
        exec(enc_r(5'd8, 5'd0, 5'd0, 5'd0, mse_pkg::FN_MTLO));
        exec(enc_r(5'd0, 5'd10, 5'd14, 5'd31, mse_pkg::FN_SRA));
        exec(enc_r(5'd9, 5'd8, 5'd15, 5'd0, mse_pkg::FN_SRLV));
        exec(enc_r(5'd8, 5'd9, 5'd16, 5'd0, mse_pkg::FN_SLT));
        exec(enc_r(5'd8, 5'd9, 5'd0, 5'd0, mse_pkg::FN_ADDU));
        send_word(1'b1, '0, 10'h3ff, 32'hffff_ffff);
        send_word(1'b1, '0, 10'h000, 32'h8081_8283);
        exec(enc_i(mse_pkg::OP_LB, 5'd0, 5'd17, 16'h0003));
        exec(enc_i(mse_pkg::OP_LH, 5'd0, 5'd18, 16'h0001));
        exec(enc_i(mse_pkg::OP_SW, 5'd0, 5'd10, 16'h0002));
        exec(enc_i(mse_pkg::OP_LHU, 5'd0, 5'd19, 16'h0ffe));
        exec(enc_i(mse_pkg::OP_REGIMM, 5'd9, mse_pkg::RI_BLTZAL, 16'h0010));
        exec(enc_i(mse_pkg::OP_REGIMM, 5'd9, 5'h05, 16'h0010));
        exec({mse_pkg::OP_J, 26'h3ff_ffff});
        exec(enc_r(5'd9, 5'd0, 5'd20, 5'd0, mse_pkg::FN_JALR));
        exec(enc_r(5'd0, 5'd0, 5'd0, 5'd0, 6'h01));
        exec({6'h3f, 26'h0});
        exec(enc_r(5'd0, 5'd0, 5'd0, 5'd0, mse_pkg::FN_SYSCALL));

        // random phases with different start pcs
        pcs = '{32'h0000_0000, 32'hffff_fffc, {$urandom} & 32'hffff_fffc};
        for (int ph = 0; ph < 4; ph++) begin
            if (ph > 0) write_start_pc(pcs[ph - 1]);
            if (ph == 3) calm = 1'b1;
            for (int k = 0; k < 255; k++) begin
                if ($urandom_range(0, 9) == 0)
                    send_word(1'b1, $urandom, 10'($urandom), $urandom);
                else
                    exec(rand_instr());
            end
        end

        // halt, then words while halted
        exec(enc_i(mse_pkg::OP_ADDIU, 5'd0, mse_pkg::REG_V0, 16'h000a));
        exec(enc_r(5'd0, 5'd0, 5'd0, 5'd0, mse_pkg::FN_SYSCALL));
        exec(enc_i(mse_pkg::OP_ADDIU, 5'd0, 5'd8, 16'h0001));
        send_word(1'b1, '0, 10'h155, 32'h5555_aaaa);
        in_ch.valid = 1'b0;
        sending = 1'b0;

        while (pending != 0) @(negedge i_clk);
        repeat (50) @(negedge i_clk);
        if (fail_cnt == 0 && pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
